### rtl/core/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg: shared types and codes of the positional list core
// Holds the command and response beat types, operation and status codes,
// and the control bundle that drives the chain of storage cells.
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 4;
  localparam int LEN_W   = 5;

  // Operation codes carried in the func field
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status codes of a response beat
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic                      func;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } plc_cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] removed_value;
    logic [1:0]                status;
    logic [LEN_W-1:0]          length;
  } plc_rsp_t;

  // Shift control broadcast to every cell in the chain
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [POS_W-1:0] pos;
  } plc_shift_t;

endpackage

### rtl/core/positional_list_insert_remove_core.sv
// The done strobe with its result follows an accepted start in the next cycle.
// Throughput: one operation per cycle; busy stays low, since every cell of the
// chain shifts in parallel in the same cycle as the command beat.
// Reset: synchronous rst empties the list (count to zero) and drops done; the
// entry cells keep stale data that is never read below the count.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// positional_list_insert_remove_core: ordered list with positional edits
// Inserts a value at a position or removes the entry at a position, keeping
// the entries in a chain of cells that shift by one place per operation.
// ----------------------------------------------------------------------------
module positional_list_insert_remove_core #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  plc_pkg::plc_cmd_t cmd,
  output logic              done,
  output plc_pkg::plc_rsp_t rsp
);
  import plc_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int READ_N = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic signed [VALUE_W-1:0] cell_data [CAPACITY];
  logic signed [VALUE_W-1:0] read_value;
  logic [CNT_W-1:0]          pos_ext;
  logic                      is_full;
  logic                      pos_valid;
  logic                      ins_ok;
  logic                      rem_ok;
  plc_shift_t                shift;
  plc_rsp_t                  rsp_next;

  assign busy = 1'b0;

  // Decode the command beat
  assign pos_ext   = CNT_W'(cmd.position);
  assign is_full   = (count == CNT_W'(CAPACITY));
  assign pos_valid = ((CNT_W >= POS_W) || (cmd.position < POS_W'(count))) &&
                     (pos_ext < count);
  assign ins_ok    = start && (cmd.func == OP_INSERT) && !is_full;
  assign rem_ok    = start && (cmd.func == OP_REMOVE) && pos_valid;

  // Clamp the insert position to the count to append past the end
  always_comb begin
    shift.ins = ins_ok;
    shift.rem = rem_ok;
    shift.pos = cmd.position;
    if (cmd.func == OP_INSERT && !pos_valid) begin
      shift.pos = POS_W'(count);
    end
  end

  // Build the chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] lower;
    logic signed [VALUE_W-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = cell_data[i];
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = cell_data[i];
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end
    plc_cell #(.IDX(i)) u_cell (
      .clk        (clk),
      .ctl        (shift),
      .new_value  (cmd.value),
      .from_lower (lower),
      .from_upper (upper),
      .data       (cell_data[i])
    );
  end

  // Select the entry at the addressable position
  always_comb begin
    read_value = '0;
    for (int k = 0; k < READ_N; k++) begin
      if (cmd.position == POS_W'(k)) begin
        read_value = cell_data[k];
      end
    end
  end

  // Form the next count and the response beat
  always_comb begin
    count_next             = count;
    rsp_next.removed_value = '0;
    rsp_next.status        = ST_OK;
    if (cmd.func == OP_INSERT) begin
      if (is_full) begin
        rsp_next.status = ST_FULL;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (pos_valid) begin
        rsp_next.removed_value = read_value;
        count_next             = count - CNT_W'(1);
      end else begin
        rsp_next.removed_value = -32'sd1;
        rsp_next.status        = ST_NOT_FOUND;
      end
    end
    rsp_next.length = LEN_W'(count_next);
  end

  // Advance the count and register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rsp <= rsp_next;
    end
  end

  // A result beat only follows an accepted command
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start))
    else $error("done without a preceding start");

  // The count never runs past the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // A refused insert leaves the count unchanged
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.func == OP_INSERT && is_full |=> count == $past(count))
    else $error("count changed on insert into a full list");

  // A not-found remove reports -1 and keeps the count
  a_not_found: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == ST_NOT_FOUND |->
      rsp.removed_value == -32'sd1 && count == $past(count))
    else $error("not-found remove changed state or value");

endmodule

### rtl/core/plc_cell.sv
// ----------------------------------------------------------------------------
// plc_cell: one storage place of the positional list
// Holds one entry; on insert it takes the new value or its lower neighbor's
// entry, on remove it takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
module plc_cell #(
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  plc_pkg::plc_shift_t                ctl,
  input  logic signed [plc_pkg::VALUE_W-1:0] new_value,
  input  logic signed [plc_pkg::VALUE_W-1:0] from_lower,
  input  logic signed [plc_pkg::VALUE_W-1:0] from_upper,
  output logic signed [plc_pkg::VALUE_W-1:0] data
);
  import plc_pkg::*;

  localparam int              POS_MAX = (1 << POS_W) - 1;
  localparam logic            BEYOND  = (IDX > POS_MAX);
  localparam logic [POS_W-1:0] IDX_LO = POS_W'(IDX);

  logic at_pos;
  logic above_pos;

  // Compare this cell's place against the operation position
  assign at_pos    = !BEYOND && (IDX_LO == ctl.pos);
  assign above_pos = BEYOND || (IDX_LO > ctl.pos);

  // Load new value, shift up on insert, shift down on remove
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (at_pos) begin
        data <= new_value;
      end else if (above_pos) begin
        data <= from_lower;
      end
    end else if (ctl.rem) begin
      if (at_pos || above_pos) begin
        data <= from_upper;
      end
    end
  end

endmodule
